@@ src/cnv_pkg.sv @@
package cnv_pkg;

    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int LEN_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int TYPE_W      = 3;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEN_W-1:0] MIN_LENGTH_RESET = 5'd13;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 5'd19;
    localparam logic [LEN_W-1:0] COUNT_MAX        = 5'd31;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_LENGTH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LENGTH = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NON_DIGIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LEN   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_LUHN_FAIL = 2'd3;

    localparam logic [TYPE_W-1:0] TYPE_AMEX       = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_JCB        = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_VISA       = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_MASTERCARD = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_MAESTRO    = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_OTHER      = 3'd5;

    typedef enum logic [1:0] {
        CHAR_SPACE = 2'd0,
        CHAR_DIGIT = 2'd1,
        CHAR_BAD   = 2'd2
    } char_kind_t;

    typedef struct packed {
        char_kind_t           kind;
        logic [DIGIT_W-1:0]   digit;
        logic                 last;
    } cnv_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [TYPE_W-1:0]    card_type;
        logic [LEN_W-1:0]     digit_total;
    } cnv_result_t;

endpackage

@@ src/card_number_validator.sv @@
// Card number check: one character per transaction on the slave side, closing character
// marked by tlast; one result per number on the master side. Whitespace is skipped, any
// other non-digit flags the number. Sustained rate is one character per clock: the front
// end classifies a character in the cycle it is accepted, a QUEUE_DEPTH-entry queue sits
// in front of the back end, and the back end folds one queued character per cycle into
// the digit count and both Luhn sums. A result is registered when its closing character
// leaves the queue; only closing characters wait on the single output register, so input
// stalls only when a result stays untaken long enough to fill the queue. The user writes
// length limits (cfg index 0 min_length, 1 max_length) only while idle; not enforced.
module card_number_validator #(
    parameter int QUEUE_DEPTH = cnv_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cnv_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cnv_pkg::LEN_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cnv_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] char_code
    input  logic                            s_tlast,   // last_char
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cnv_pkg::OUT_DATA_W-1:0]  m_tdata    // [1:0] status, [4:2] card_type,
                                                       // [9:5] digit_total
);
    import cnv_pkg::*;

    logic [LEN_W-1:0] min_length_reg;
    logic [LEN_W-1:0] max_length_reg;
    logic             queue_full;
    logic             push;
    cnv_item_t        push_item;
    logic             pop;
    logic             head_valid;
    cnv_item_t        head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MIN_LENGTH_RESET;
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MIN_LENGTH: min_length_reg <= cfg_data;
                REG_MAX_LENGTH: max_length_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    cnv_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .item       (push_item)
    );

    cnv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    cnv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .min_length (min_length_reg),
        .max_length (max_length_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

@@ src/cnv_front.sv @@
module cnv_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cnv_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] char_code
    input  logic                            s_tlast,
    input  logic                            queue_full,
    output logic                            push,
    output cnv_pkg::cnv_item_t              item
);
    import cnv_pkg::*;

    logic [CHAR_W-1:0] char_code;

    assign char_code = s_tdata[CHAR_W-1:0];
    assign s_tready  = !queue_full;

    always_comb
    begin
        item.digit = char_code[DIGIT_W-1:0];
        item.last  = s_tlast;
        if (char_code inside {8'h20, [8'h09:8'h0D]})
        begin
            item.kind = CHAR_SPACE;
        end
        else if (char_code inside {[8'h30:8'h39]})
        begin
            item.kind = CHAR_DIGIT;
        end
        else
        begin
            item.kind = CHAR_BAD;
        end
    end

    // drop whitespace unless it closes the number
    assign push = s_tvalid && s_tready && !(item.kind == CHAR_SPACE && !s_tlast);

endmodule

@@ src/cnv_queue.sv @@
module cnv_queue #(
    parameter int DEPTH = cnv_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cnv_pkg::cnv_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output cnv_pkg::cnv_item_t  head_item
);
    import cnv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cnv_item_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/cnv_back.sv @@
module cnv_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [cnv_pkg::LEN_W-1:0]       min_length,
    input  logic [cnv_pkg::LEN_W-1:0]       max_length,
    input  logic                            head_valid,
    input  cnv_pkg::cnv_item_t              head_item,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cnv_pkg::OUT_DATA_W-1:0]  m_tdata    // [1:0] status, [4:2] card_type,
                                                       // [9:5] digit_total
);
    import cnv_pkg::*;

    logic [DIGIT_W-1:0] sum_even_reg, sum_even_next;
    logic [DIGIT_W-1:0] sum_odd_reg, sum_odd_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic               bad_reg, bad_next;
    logic               overflow_reg, overflow_next;
    logic [DIGIT_W-1:0] first_reg, first_next;
    logic [DIGIT_W-1:0] second_reg, second_next;
    logic               out_valid_reg;
    cnv_result_t        result_reg, result_next;

    logic [DIGIT_W:0]   dbl;
    logic [DIGIT_W-1:0] dd;
    logic [DIGIT_W-1:0] add_even, add_odd;
    logic [DIGIT_W:0]   raw_even, raw_odd;
    logic [DIGIT_W-1:0] sum_sel;

    assign pop = head_valid && (!head_item.last || !out_valid_reg || m_tready);

    always_comb
    begin
        dbl = {head_item.digit, 1'b0};
        dd  = (dbl > 5'd9) ? DIGIT_W'(dbl - 5'd9) : dbl[DIGIT_W-1:0];
        if (!count_reg[0])
        begin
            add_even = dd;
            add_odd  = head_item.digit;
        end
        else
        begin
            add_even = head_item.digit;
            add_odd  = dd;
        end
        raw_even = {1'b0, sum_even_reg} + {1'b0, add_even};
        raw_odd  = {1'b0, sum_odd_reg} + {1'b0, add_odd};

        sum_even_next = sum_even_reg;
        sum_odd_next  = sum_odd_reg;
        count_next    = count_reg;
        bad_next      = bad_reg;
        overflow_next = overflow_reg;
        first_next    = first_reg;
        second_next   = second_reg;

        case (head_item.kind)
            CHAR_DIGIT:
            begin
                if (count_reg == '0)
                begin
                    first_next = head_item.digit;
                end
                else if (count_reg == LEN_W'(1))
                begin
                    second_next = head_item.digit;
                end
                sum_even_next = (raw_even >= 5'd10) ? DIGIT_W'(raw_even - 5'd10)
                                                    : raw_even[DIGIT_W-1:0];
                sum_odd_next  = (raw_odd >= 5'd10) ? DIGIT_W'(raw_odd - 5'd10)
                                                   : raw_odd[DIGIT_W-1:0];
                if (count_reg == COUNT_MAX)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            CHAR_BAD:
            begin
                bad_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        sum_sel = count_next[0] ? sum_odd_next : sum_even_next;

        if (bad_next)
        begin
            result_next.status = STATUS_NON_DIGIT;
        end
        else if (overflow_next || count_next < min_length || count_next > max_length)
        begin
            result_next.status = STATUS_BAD_LEN;
        end
        else if (sum_sel != '0)
        begin
            result_next.status = STATUS_LUHN_FAIL;
        end
        else
        begin
            result_next.status = STATUS_OK;
        end

        if (count_next == '0)
        begin
            result_next.card_type = TYPE_OTHER;
        end
        else
        begin
            case (first_next)
                4'd3:    result_next.card_type = (second_next inside {4'd4, 4'd7}) ?
                                                 TYPE_AMEX : TYPE_JCB;
                4'd4:    result_next.card_type = TYPE_VISA;
                4'd5:    result_next.card_type = TYPE_MASTERCARD;
                4'd6:    result_next.card_type = TYPE_MAESTRO;
                default: result_next.card_type = TYPE_OTHER;
            endcase
        end
        result_next.digit_total = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_even_reg  <= '0;
            sum_odd_reg   <= '0;
            count_reg     <= '0;
            bad_reg       <= 1'b0;
            overflow_reg  <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && head_item.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                if (head_item.last)
                begin
                    // emit and clear for the next number
                    sum_even_reg  <= '0;
                    sum_odd_reg   <= '0;
                    count_reg     <= '0;
                    bad_reg       <= 1'b0;
                    overflow_reg  <= 1'b0;
                    first_reg     <= '0;
                    second_reg    <= '0;
                end
                else
                begin
                    sum_even_reg  <= sum_even_next;
                    sum_odd_reg   <= sum_odd_next;
                    count_reg     <= count_next;
                    bad_reg       <= bad_next;
                    overflow_reg  <= overflow_next;
                    first_reg     <= first_next;
                    second_reg    <= second_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_item.last)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({result_reg.digit_total, result_reg.card_type,
                                   result_reg.status});

    a_sums_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sum_even_reg <= 4'd9 && sum_odd_reg <= 4'd9)
        else $error("Luhn sum left the mod 10 range");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_item.last |=> count_reg == '0 && !bad_reg && !overflow_reg)
        else $error("state not cleared after the closing character");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !head_item.last && head_item.kind == CHAR_DIGIT && count_reg == COUNT_MAX
        |=> count_reg == COUNT_MAX && overflow_reg)
        else $error("digit count wrapped instead of saturating");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(result_reg))
        else $error("pending result overwritten");

    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.status == STATUS_OK
        |-> result_reg.digit_total >= min_length && result_reg.digit_total <= max_length)
        else $error("ok status with a length outside the limits");

endmodule

@@ tb/sv/card_number_validator_tb.sv @@
module card_number_validator_tb;
    import cnv_pkg::*;

    typedef logic [CHAR_W-1:0] char_q_t[$];

    class luhn_scoreboard;
        logic [LEN_W-1:0]   min_len;
        logic [LEN_W-1:0]   max_len;
        logic [DIGIT_W-1:0] sum_even_dbl;
        logic [DIGIT_W-1:0] sum_odd_dbl;
        logic [LEN_W-1:0]   digit_cnt;
        logic [DIGIT_W-1:0] first_d;
        logic [DIGIT_W-1:0] second_d;
        bit                 bad_seen;
        bit                 too_long;
        cnv_result_t        pending[$];
        int                 errors;

        function new();
            min_len = MIN_LENGTH_RESET;
            max_len = MAX_LENGTH_RESET;
            errors  = 0;
            clear_number();
        endfunction

        function void clear_number();
            sum_even_dbl = '0;
            sum_odd_dbl  = '0;
            digit_cnt    = '0;
            first_d      = '0;
            second_d     = '0;
            bad_seen     = 1'b0;
            too_long     = 1'b0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [LEN_W-1:0] value);
            case (addr)
                REG_MIN_LENGTH: min_len = value;
                REG_MAX_LENGTH: max_len = value;
                default: ;
            endcase
        endfunction

        function void note_char(logic [CHAR_W-1:0] c, logic last);
            int                 d;
            int                 dd;
            bit                 is_space;
            logic [DIGIT_W-1:0] chk;
            cnv_result_t        r;
            is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d  = c - 8'h30;
                dd = (2 * d > 9) ? 2 * d - 9 : 2 * d;
                if (digit_cnt == 0)
                    first_d = d[DIGIT_W-1:0];
                else if (digit_cnt == 1)
                    second_d = d[DIGIT_W-1:0];
                if (digit_cnt[0] == 1'b0)
                begin
                    sum_even_dbl = DIGIT_W'((sum_even_dbl + dd) % 10);
                    sum_odd_dbl  = DIGIT_W'((sum_odd_dbl + d) % 10);
                end
                else
                begin
                    sum_even_dbl = DIGIT_W'((sum_even_dbl + d) % 10);
                    sum_odd_dbl  = DIGIT_W'((sum_odd_dbl + dd) % 10);
                end
                if (digit_cnt == COUNT_MAX)
                    too_long = 1'b1;
                else
                    digit_cnt++;
            end
            else if (!is_space)
                bad_seen = 1'b1;

            if (last)
            begin
                chk = digit_cnt[0] ? sum_odd_dbl : sum_even_dbl;
                if (bad_seen)
                    r.status = STATUS_NON_DIGIT;
                else if (too_long || digit_cnt < min_len || digit_cnt > max_len)
                    r.status = STATUS_BAD_LEN;
                else if (chk != 0)
                    r.status = STATUS_LUHN_FAIL;
                else
                    r.status = STATUS_OK;
                if (digit_cnt == 0)
                    r.card_type = TYPE_OTHER;
                else
                begin
                    case (first_d)
                        4'd3: r.card_type = (second_d == 4 || second_d == 7) ? TYPE_AMEX
                                                                            : TYPE_JCB;
                        4'd4: r.card_type = TYPE_VISA;
                        4'd5: r.card_type = TYPE_MASTERCARD;
                        4'd6: r.card_type = TYPE_MAESTRO;
                        default: r.card_type = TYPE_OTHER;
                    endcase
                end
                r.digit_total = digit_cnt;
                pending.push_back(r);
                clear_number();
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            cnv_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result: m_tdata expected none, actual %h", data);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (data[1:0] !== exp_r.status)
            begin
                $error("status: expected %0d, actual %0d", exp_r.status, data[1:0]);
                errors++;
            end
            if (data[4:2] !== exp_r.card_type)
            begin
                $error("card_type: expected %0d, actual %0d", exp_r.card_type, data[4:2]);
                errors++;
            end
            if (data[9:5] !== exp_r.digit_total)
            begin
                $error("digit_total: expected %0d, actual %0d", exp_r.digit_total, data[9:5]);
                errors++;
            end
            if (data[OUT_DATA_W-1:10] !== '0)
            begin
                $error("padding: expected 0, actual %h", data[OUT_DATA_W-1:10]);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [LEN_W-1:0]        cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;

    luhn_scoreboard sb = new();
    bit             burst;
    bit             hold_req;
    int             items_sent;

    card_number_validator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 25);
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_char(c, last);
        items_sent++;
    endtask

    task automatic send_number(input char_q_t num);
        foreach (num[i])
            send_char(num[i], i == num.size() - 1);
    endtask

    task automatic set_limits(input logic [LEN_W-1:0] min_v, input logic [LEN_W-1:0] max_v);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_MIN_LENGTH;
        cfg_data <= min_v;
        @(posedge clk);
        sb.write_reg(REG_MIN_LENGTH, min_v);
        cfg_addr <= REG_MAX_LENGTH;
        cfg_data <= max_v;
        @(posedge clk);
        sb.write_reg(REG_MAX_LENGTH, max_v);
        cfg_we   <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] min_v, input logic [LEN_W-1:0] max_v,
                             input int quota, input bit hold);
        char_q_t num;
        int      digits[$];
        int      start;
        int      kind;
        int      len;
        int      s;
        int      w;
        drain();
        set_limits(min_v, max_v);
        if (hold)
            hold_req <= 1'b1;
        start = items_sent;
        // empty number: whitespace only
        num = {8'h20};
        send_number(num);
        while (items_sent - start < quota)
        begin
            burst = ($urandom_range(0, 3) == 0);
            kind  = $urandom_range(0, 99);
            num.delete();
            digits.delete();
            if (kind < 90)
            begin
                if (kind >= 80)
                    len = $urandom_range(28, 35);
                else if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(1, 12);
                else
                    len = $urandom_range(12, 19);
                case ($urandom_range(0, 4))
                    0: digits.push_back(3);
                    1: digits.push_back(4);
                    2: digits.push_back(5);
                    3: digits.push_back(6);
                    default: digits.push_back($urandom_range(0, 9));
                endcase
                if (digits[0] == 3 && $urandom_range(0, 1) == 1)
                    digits.push_back($urandom_range(0, 1) ? 4 : 7);
                while (digits.size() < len)
                    digits.push_back($urandom_range(0, 9));
                // make the check digit right most of the time
                if ($urandom_range(0, 9) < 7 && digits.size() > 1)
                begin
                    s = 0;
                    for (int i = 0; i < digits.size() - 1; i++)
                    begin
                        w = digits[digits.size() - 2 - i];
                        if (i % 2 == 0)
                            w = (2 * w > 9) ? 2 * w - 9 : 2 * w;
                        s += w;
                    end
                    digits[digits.size() - 1] = (10 - s % 10) % 10;
                end
                foreach (digits[i])
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        w = $urandom_range(8, 13);
                        num.push_back(w == 8 ? 8'h20 : 8'(w));
                    end
                    num.push_back(8'h30 + 8'(digits[i]));
                end
                if ($urandom_range(0, 9) == 0)
                    num.push_back(8'h0A);
                if (kind >= 70 && kind < 80)
                    num[$urandom_range(0, num.size() - 1)] = 8'($urandom_range(0, 255));
            end
            else
            begin
                len = $urandom_range(1, 8);
                repeat (len) num.push_back(8'($urandom_range(0, 255)));
            end
            send_number(num);
        end
        burst = 1'b0;
        drain();
    endtask

    // receiver: random backpressure, one long hold-off on request
    initial
    begin
        int stall_left;
        int hold_left;
        int ready_pct;
        int cyc;
        bit hold_done;
        m_tready   = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        ready_pct  = 100;
        cyc        = 0;
        hold_done  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (cyc % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    default: ready_pct = 40;
                endcase
            end
            cyc++;
            if (hold_req && !hold_done)
            begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(1, 100) <= ready_pct)
                m_tready <= 1'b1;
            else
            begin
                stall_left = pick_gap();
                m_tready <= 1'b0;
            end
        end
    end

    initial
    begin
        char_q_t num;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        burst      = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone 3, no second digit
        num = {8'h33};
        send_number(num);
        num = {8'hFF};
        send_number(num);
        // whitespace only
        num = {8'h20, 8'h0D};
        send_number(num);
        // non-digit after the digits, first two digits still decide the type
        num = {8'h09, 8'h33, 8'h37, 8'h00};
        send_number(num);
        // characters bordering the digit and whitespace ranges
        num = {8'h2F, 8'h3A, 8'h08, 8'h0E};
        send_number(num);
        // shortest valid number at reset limits
        num = {8'h34};
        repeat (12) num.push_back(8'h32);
        send_number(num);

        run_phase(5'd13, 5'd19, 180, 1'b0);
        run_phase(5'd0,  5'd31, 180, 1'b1);
        run_phase(5'd1,  5'd1,  180, 1'b0);
        run_phase(5'd31, 5'd31, 180, 1'b0);
        run_phase(5'd20, 5'd5,  180, 1'b0);
        run_phase(5'd12, 5'd16, 180, 1'b0);

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
